// ===== rtl/core/roi_vdm_pkg.sv =====
// ----------------------------------------------------------------------------
// roi_vdm_pkg
// Shared widths, register indexes and types for the ROI depth-mean block.
// ----------------------------------------------------------------------------
`default_nettype none

package roi_vdm_pkg;

    // Coordinate and depth masking widths
    localparam int COORD_BITS = 10;
    localparam int DEPTH_BITS = 16;

    // Fixed field widths
    localparam int COL_W     = 10;
    localparam int END_W     = 11;
    localparam int DEPTH_W   = 16;
    localparam int SUM_W     = 36;
    localparam int CNT_W     = 21;
    localparam int MEAN_W    = 16;
    localparam int STEP_W    = $clog2(MEAN_W);

    localparam logic [COL_W-1:0]   COORD_MASK =
        COL_W'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [DEPTH_W-1:0] DEPTH_MASK =
        DEPTH_W'((64'd1 << DEPTH_BITS) - 64'd1);

    // Stream widths
    localparam int S_TDATA_W = 40;  // depth, col, row, padded
    localparam int M_TDATA_W = 40;  // mean, count, padded

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIM = 3'd4;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = 16'd5000;

    typedef struct packed {
        logic [COL_W-1:0]   col_start;
        logic [COL_W-1:0]   row_start;
        logic [END_W-1:0]   col_end;
        logic [END_W-1:0]   row_end;
        logic [DEPTH_W-1:0] depth_limit;
    } t_roi_cfg;

    // One finished frame waiting for its division
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_job;

    // Queue to back-end handshake
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

endpackage

`default_nettype wire

// ===== rtl/core/roi_valid_depth_mean_top.sv =====
// ----------------------------------------------------------------------------
// roi_valid_depth_mean_top
// Mean and count of valid depth pixels inside a rectangular region, per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake               Payload
//  -------   ---  ----------------------  ------------------------------------
//  pixels    in   s_tvalid / s_tready     tdata: depth, col, row; tlast: last
//  results   out  m_tvalid / m_tready     tdata: mean, count; tuser: empty
//  config    in   cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
//  Pixels are taken one per cycle while s_tready is high; the accumulator
//  adds a counted pixel in the cycle it arrives. Each frame end pushes its sum
//  and count into a two-entry queue. The divider loads a frame, takes 16
//  quotient steps and hands over once the output register is free; a frame
//  with nothing counted skips the steps. s_tready drops only while both queue
//  entries hold frames not yet taken by the divider. A result waits in the
//  output register while the divider starts on the next frame.
//  Reset (synchronous, active low) clears sums, queue, divider and output valid,
//  and returns the config registers to their reset values.
//
`default_nettype none

module roi_valid_depth_mean_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // pixel stream: [15:0] depth, [25:16] col, [35:26] row, [39:36] zero
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [roi_vdm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                                 s_tlast,
    // result stream: [15:0] mean_depth, [36:16] valid_count, [39:37] zero
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [roi_vdm_pkg::M_TDATA_W-1:0]         m_tdata,
    // [0] region_empty
    output logic                                      m_tuser,
    // config write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [roi_vdm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [roi_vdm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    roi_vdm_pkg::t_roi_cfg r_cfg;
    roi_vdm_pkg::t_job     job;
    roi_vdm_pkg::t_job_req req;
    logic                  push, full, pop;
    logic [roi_vdm_pkg::MEAN_W-1:0] mean;
    logic [roi_vdm_pkg::CNT_W-1:0]  count;
    logic                           empty;

    // config registers; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.col_start   <= '0;
            r_cfg.row_start   <= '0;
            r_cfg.col_end     <= '0;
            r_cfg.row_end     <= '0;
            r_cfg.depth_limit <= roi_vdm_pkg::DEPTH_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                roi_vdm_pkg::CFG_COL_START: begin
                    r_cfg.col_start <= i_cfg_data[roi_vdm_pkg::COL_W-1:0];
                end
                roi_vdm_pkg::CFG_ROW_START: begin
                    r_cfg.row_start <= i_cfg_data[roi_vdm_pkg::COL_W-1:0];
                end
                roi_vdm_pkg::CFG_COL_END: begin
                    r_cfg.col_end <= i_cfg_data[roi_vdm_pkg::END_W-1:0];
                end
                roi_vdm_pkg::CFG_ROW_END: begin
                    r_cfg.row_end <= i_cfg_data[roi_vdm_pkg::END_W-1:0];
                end
                roi_vdm_pkg::CFG_DEPTH_LIM: begin
                    r_cfg.depth_limit <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // a pixel is taken only while the queue has room for a possible frame end
    assign s_tready = !full;

    roi_vdm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_valid (s_tvalid && s_tready),
        .i_pix_depth (s_tdata[15:0]),
        .i_pix_col   (s_tdata[25:16]),
        .i_pix_row   (s_tdata[35:26]),
        .i_pix_last  (s_tlast),
        .o_push      (push),
        .o_job       (job)
    );

    roi_vdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_req   (req)
    );

    roi_vdm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_mean  (mean),
        .o_count (count),
        .o_empty (empty)
    );

    assign m_tdata = {3'b000, count, mean};
    assign m_tuser = empty;

endmodule

`default_nettype wire

// ===== rtl/core/roi_vdm_front.sv =====
// ----------------------------------------------------------------------------
// roi_vdm_front
// Pixel classifier and per-frame accumulator; emits one job per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_vdm_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire roi_vdm_pkg::t_roi_cfg          i_cfg,
    input  wire logic                           i_pix_valid,
    input  wire logic [roi_vdm_pkg::DEPTH_W-1:0] i_pix_depth,
    input  wire logic [roi_vdm_pkg::COL_W-1:0]   i_pix_col,
    input  wire logic [roi_vdm_pkg::COL_W-1:0]   i_pix_row,
    input  wire logic                           i_pix_last,
    output logic                                o_push,
    output roi_vdm_pkg::t_job                   o_job
);

    logic [roi_vdm_pkg::SUM_W-1:0]   r_sum,   n_sum;
    logic [roi_vdm_pkg::CNT_W-1:0]   r_count, n_count;
    logic [roi_vdm_pkg::END_W-1:0]   col_x, row_x;
    logic [roi_vdm_pkg::DEPTH_W-1:0] depth_x;
    logic                            in_roi, good, take;
    logic [roi_vdm_pkg::SUM_W-1:0]   acc_sum;
    logic [roi_vdm_pkg::CNT_W-1:0]   acc_count;

    assign col_x   = roi_vdm_pkg::END_W'(i_pix_col & roi_vdm_pkg::COORD_MASK);
    assign row_x   = roi_vdm_pkg::END_W'(i_pix_row & roi_vdm_pkg::COORD_MASK);
    assign depth_x = i_pix_depth & roi_vdm_pkg::DEPTH_MASK;

    assign in_roi = (col_x >= {1'b0, i_cfg.col_start}) && (col_x < i_cfg.col_end) &&
                    (row_x >= {1'b0, i_cfg.row_start}) && (row_x < i_cfg.row_end);
    assign good   = (depth_x != '0) && (depth_x < i_cfg.depth_limit);
    // top count bit set means the cap of 2^20 has been reached
    assign take   = in_roi && good && !r_count[roi_vdm_pkg::CNT_W-1];

    assign acc_sum   = take ? r_sum + roi_vdm_pkg::SUM_W'(depth_x) : r_sum;
    assign acc_count = take ? r_count + roi_vdm_pkg::CNT_W'(1) : r_count;

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (i_pix_valid) begin
            n_sum   = i_pix_last ? '0 : acc_sum;
            n_count = i_pix_last ? '0 : acc_count;
        end
    end

    assign o_push      = i_pix_valid && i_pix_last;
    assign o_job.sum   = acc_sum;
    assign o_job.count = acc_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/roi_vdm_queue.sv =====
// ----------------------------------------------------------------------------
// roi_vdm_queue
// Two-entry job queue between the accumulator and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_vdm_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire roi_vdm_pkg::t_job     i_job,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output roi_vdm_pkg::t_job_req      o_req
);

    roi_vdm_pkg::t_job r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_cnt, n_cnt;
    logic        do_push, do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && (r_cnt != 2'd0);
    assign o_req.valid = (r_cnt != 2'd0);
    assign o_req.job   = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/roi_vdm_back.sv =====
// ----------------------------------------------------------------------------
// roi_vdm_back
// Bit-serial restoring divider producing the mean, plus the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_vdm_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire roi_vdm_pkg::t_job_req             i_req,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [roi_vdm_pkg::MEAN_W-1:0]         o_mean,
    output logic [roi_vdm_pkg::CNT_W-1:0]          o_count,
    output logic                                   o_empty
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Quotient bits shift into r_quo as dividend bits shift out.
    logic [roi_vdm_pkg::CNT_W-1:0]  r_rem,  n_rem;
    logic [roi_vdm_pkg::MEAN_W-1:0] r_quo,  n_quo;
    logic [roi_vdm_pkg::CNT_W-1:0]  r_div,  n_div;
    logic [roi_vdm_pkg::STEP_W-1:0] r_step, n_step;

    logic                           r_out_valid, n_out_valid;
    logic [roi_vdm_pkg::MEAN_W-1:0] r_out_mean;
    logic [roi_vdm_pkg::CNT_W-1:0]  r_out_cnt;
    logic                           r_out_empty;

    logic [roi_vdm_pkg::CNT_W:0]    trial, diff;
    logic                           ge, out_free, load;

    assign trial    = {r_rem, r_quo[roi_vdm_pkg::MEAN_W-1]};
    assign diff     = trial - {1'b0, r_div};
    assign ge       = (trial >= {1'b0, r_div});
    assign out_free = !r_out_valid || i_ready;
    assign load     = (r_state == S_HOLD) && out_free;
    assign o_pop    = (r_state == S_IDLE) && i_req.valid;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_div  = i_req.job.count;
                    n_step = '0;
                    if (i_req.job.count == '0) begin
                        n_quo   = '0;
                        n_state = S_HOLD;
                    end else begin
                        // sum < count * 2^16, so the upper part is already below count
                        n_rem   = roi_vdm_pkg::CNT_W'(
                            i_req.job.sum[roi_vdm_pkg::SUM_W-1:roi_vdm_pkg::MEAN_W]);
                        n_quo   = i_req.job.sum[roi_vdm_pkg::MEAN_W-1:0];
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = ge ? diff[roi_vdm_pkg::CNT_W-1:0] : trial[roi_vdm_pkg::CNT_W-1:0];
                n_quo  = {r_quo[roi_vdm_pkg::MEAN_W-2:0], ge};
                n_step = r_step + roi_vdm_pkg::STEP_W'(1);
                if (r_step == roi_vdm_pkg::STEP_W'(roi_vdm_pkg::MEAN_W - 1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        if (load) begin
            r_out_mean  <= r_quo;
            r_out_cnt   <= r_div;
            r_out_empty <= (r_div == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_mean  = r_out_mean;
    assign o_count = r_out_cnt;
    assign o_empty = r_out_empty;

endmodule

`default_nettype wire

// ===== rtl/core/roi_vdm_checker.sv =====
// ----------------------------------------------------------------------------
// roi_vdm_checker
// Port-level checks on the result stream of the ROI depth-mean block.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_vdm_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [roi_vdm_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                               m_tuser
);

    // result held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // empty flag agrees with a zero count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == (m_tdata[36:16] == 21'd0)))
        else $error("empty flag disagrees with count");

    // empty frame gives a zero mean
    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> (m_tdata[15:0] == 16'd0))
        else $error("empty frame with non-zero mean");

    // count never exceeds the cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[36] |-> (m_tdata[35:16] == 20'd0))
        else $error("count above cap");

    // nothing comes out straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind roi_valid_depth_mean_top roi_vdm_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== test/tb_roi_valid_depth_mean_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_roi_valid_depth_mean_top
// Drives pixel frames through the ROI depth-mean block under changing region
// and limit settings, with random idling on both streams. Every frame result
// is checked against an untimed model of the region filter, accumulator and
// divider.
// ----------------------------------------------------------------------------

import roi_vdm_pkg::*;

// counted pixels per frame saturate here
localparam int unsigned COUNT_CAP = 32'd1 << 20;

typedef struct {
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  count;
    logic              empty;
} t_frame_stat;

// Untimed copy of the block: register file, running sum/count, frame results
class frame_mean_model;
    logic [COL_W-1:0]   col_start;
    logic [COL_W-1:0]   row_start;
    logic [END_W-1:0]   col_end;
    logic [END_W-1:0]   row_end;
    logic [DEPTH_W-1:0] depth_limit;
    logic [SUM_W-1:0]   depth_sum;
    logic [CNT_W-1:0]   pixel_count;
    t_frame_stat        pending[$];
    int unsigned        frames;
    int unsigned        empty_frames;
    int unsigned        checked;
    int unsigned        failures;

    function new();
        col_start    = '0;
        row_start    = '0;
        col_end      = '0;
        row_end      = '0;
        depth_limit  = DEPTH_LIMIT_RESET;
        depth_sum    = '0;
        pixel_count  = '0;
        frames       = 0;
        empty_frames = 0;
        checked      = 0;
        failures     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_COL_START: col_start   = data[COL_W-1:0];
            CFG_ROW_START: row_start   = data[COL_W-1:0];
            CFG_COL_END:   col_end     = data[END_W-1:0];
            CFG_ROW_END:   row_end     = data[END_W-1:0];
            CFG_DEPTH_LIM: depth_limit = data[DEPTH_W-1:0];
            default: ;
        endcase
    endfunction

    function void take_pixel(logic [DEPTH_W-1:0] depth, logic [COL_W-1:0] col,
                             logic [COL_W-1:0] row, logic last);
        logic [DEPTH_W-1:0] d;
        logic [COL_W-1:0]   c;
        logic [COL_W-1:0]   r;
        logic               hit;
        logic               good;
        t_frame_stat        res;
        d    = depth & DEPTH_MASK;
        c    = col & COORD_MASK;
        r    = row & COORD_MASK;
        hit  = (c >= col_start) && ({1'b0, c} < col_end) &&
               (r >= row_start) && ({1'b0, r} < row_end);
        good = (d != '0) && (d < depth_limit);
        if (hit && good && pixel_count < COUNT_CAP) begin
            depth_sum   = depth_sum + SUM_W'(d);
            pixel_count = pixel_count + 1'b1;
        end
        if (last) begin
            res.empty = (pixel_count == '0);
            res.count = pixel_count;
            res.mean  = res.empty ? '0 : MEAN_W'(depth_sum / SUM_W'(pixel_count));
            pending = {pending, res};
            frames++;
            if (res.empty)
                empty_frames++;
            depth_sum   = '0;
            pixel_count = '0;
        end
    endfunction

    function void check_result(logic [MEAN_W-1:0] mean, logic [CNT_W-1:0] count,
                               logic empty);
        t_frame_stat want;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("result with no frame pending: mean %0d count %0d empty %0b",
                         mean, count, empty);
            return;
        end
        want = pending.pop_front();
        if (mean !== want.mean || count !== want.count || empty !== want.empty) begin
            failures++;
            if (failures <= 10)
                $display("frame %0d: expected mean %0d count %0d empty %0b, got %0d %0d %0b",
                         checked, want.mean, want.count, want.empty, mean, count, empty);
        end
        checked++;
    endfunction
endclass

module tb_roi_valid_depth_mean_top;

    localparam int QUIET_LIMIT     = 5000;  // cycles without any handshake
    localparam int HOLD_CYCLES     = 300;   // long result back-pressure
    localparam int DRAIN_CYCLES    = 40;    // divider may still be busy with the last frame
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_PIXELS    = 95;
    localparam int HOLD_PHASE      = 3;
    localparam int CFG_SPARE_COUNT = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_DEPTH_LIM + 1'b1;

    typedef enum {SETUP_FULL, SETUP_RECT, SETUP_NARROW, SETUP_INVERTED, SETUP_RAW}
        t_setup_kind;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // [15:0] depth, [25:16] col, [35:26] row
    logic                  s_tlast;    // last pixel of frame
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // [15:0] mean_depth, [36:16] valid_count
    logic                  m_tuser;    // [0] region_empty
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frame_mean_model model;

    bit          tx_idle;                // sender may insert gaps
    bit          rx_idle;                // receiver may stall
    bit          hold_req;               // ask the receiver for a long hold-off
    int unsigned quiet_cycles = 0;
    int unsigned input_stalls = 0;
    int unsigned cfg_writes   = 0;
    int unsigned pixels_sent  = 0;

    roi_valid_depth_mean_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: any accepted item on any channel counts as progress.
    // Also tallies cycles where the block pushes back on the pixel stream.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (s_tvalid && !s_tready)
            input_stalls <= input_stalls + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Gap lengths: mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 75)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Result side: m_tready set once per falling edge, item taken at the rising edge
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge i_clk);
            if (m_tvalid && m_tready)
                model.check_result(m_tdata[MEAN_W-1:0], m_tdata[MEAN_W +: CNT_W], m_tuser);
        end
    end

    // One pixel item; tvalid stays high into the next item unless a gap is drawn
    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic [COL_W-1:0] col,
                              input logic [COL_W-1:0] row, input logic last);
        int unsigned gap;
        gap = (tx_idle && $urandom_range(0, 4) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - DEPTH_W - 2 * COL_W){1'b0}}, row, col, depth};
        s_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        model.take_pixel(depth, col, row, last);
        pixels_sent++;
    endtask

    task automatic stop_pixels();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        model.set_register(idx, data);
        cfg_writes++;
    endtask

    // Full register set; optionally pokes the unused indexes with junk first
    task automatic apply_setup(input logic [CFG_DATA_W-1:0] cs, input logic [CFG_DATA_W-1:0] rs,
                               input logic [CFG_DATA_W-1:0] ce, input logic [CFG_DATA_W-1:0] re,
                               input logic [CFG_DATA_W-1:0] lim, input bit spare);
        if (spare)
            for (int k = 0; k < CFG_SPARE_COUNT; k++)
                write_register(CFG_IDX_W'(CFG_SPARE + k), CFG_DATA_W'($urandom));
        write_register(CFG_COL_START, cs);
        write_register(CFG_ROW_START, rs);
        write_register(CFG_COL_END, ce);
        write_register(CFG_ROW_END, re);
        write_register(CFG_DEPTH_LIM, lim);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every expected result has been checked, then let the block idle
    task automatic wait_drained();
        while (model.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] cs, rs, ce, re, lim;
        t_setup_kind           kind;
        int unsigned           pick;
        kind = t_setup_kind'($urandom_range(0, 4));
        cs = CFG_DATA_W'($urandom_range(0, 1023));
        rs = CFG_DATA_W'($urandom_range(0, 1023));
        ce = CFG_DATA_W'($urandom_range(cs, 1024));
        re = CFG_DATA_W'($urandom_range(rs, 1024));
        case (kind)
            SETUP_FULL: begin
                cs = '0;
                rs = '0;
                ce = 1024;
                re = 1024;
            end
            SETUP_NARROW: begin
                cs = CFG_DATA_W'($urandom_range(0, 1020));
                rs = CFG_DATA_W'($urandom_range(0, 1020));
                ce = CFG_DATA_W'(cs + $urandom_range(1, 4));
                re = CFG_DATA_W'(rs + $urandom_range(1, 4));
            end
            SETUP_INVERTED: ce = CFG_DATA_W'($urandom_range(0, cs));  // end at or before start
            SETUP_RAW: begin                               // upper bits are junk
                cs = CFG_DATA_W'($urandom);
                rs = CFG_DATA_W'($urandom);
                ce = CFG_DATA_W'($urandom);
                re = CFG_DATA_W'($urandom);
            end
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 10)
            lim = 1;
        else if (pick < 20)
            lim = '1;
        else if (pick < 25)
            lim = '0;
        else if (pick < 45)
            lim = DEPTH_LIMIT_RESET;
        else if (pick < 70)
            lim = CFG_DATA_W'($urandom_range(100, 3000));
        else
            lim = CFG_DATA_W'($urandom_range(1, 65535));
        apply_setup(cs, rs, ce, re, lim, $urandom_range(0, 3) == 0);
    endtask

    // Mostly inside the region when there is one, otherwise anywhere
    function automatic logic [COL_W-1:0] pick_coord(logic [COL_W-1:0] lo, logic [END_W-1:0] hi);
        if ({1'b0, lo} < hi && $urandom_range(0, 9) < 7)
            return COL_W'($urandom_range(lo, hi - 1'b1));
        return COL_W'($urandom);
    endfunction

    task automatic send_random_pixel(input logic last);
        logic [DEPTH_W-1:0] d;
        logic [DEPTH_W-1:0] lim;
        logic [COL_W-1:0]   c;
        logic [COL_W-1:0]   r;
        int unsigned        pick;
        lim  = model.depth_limit;
        c    = pick_coord(model.col_start, model.col_end);
        r    = pick_coord(model.row_start, model.row_end);
        pick = $urandom_range(0, 99);
        // depth: no measurement, right on the limit, just below it, max, noise, in range
        if (pick < 8)
            d = '0;
        else if (pick < 16)
            d = lim;
        else if (pick < 24)
            d = lim - 1'b1;
        else if (pick < 30)
            d = '1;
        else if (pick < 40 || lim < 2)
            d = DEPTH_W'($urandom);
        else
            d = DEPTH_W'($urandom_range(1, lim - 1'b1));
        send_pixel(d, c, r, last);
    endtask

    task automatic random_phase(input int unsigned quota, input bit with_hold, input bit busy);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        random_setup();
        tx_idle = !busy && $urandom_range(0, 3) != 0;
        rx_idle = !busy && $urandom_range(0, 3) != 0;
        if (with_hold) begin
            // short frames back to back so the frame queue fills while results sit
            tx_idle  = 1'b0;
            hold_req = 1'b1;
        end
        while (sent < quota) begin
            if (with_hold)
                len = $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 85)
                len = $urandom_range(1, 24);
            else
                len = $urandom_range(25, 90);
            for (int unsigned k = 1; k <= len; k++)
                send_random_pixel(k == len);
            sent += len;
        end
        stop_pixels();
        wait_drained();
    endtask

    initial begin : stimulus
        int unsigned failures;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_req    = 1'b0;
        model       = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // reset region is 0..0, i.e. empty: nothing may count
        send_pixel(100, 0, 0, 1'b0);
        send_pixel(200, 0, 0, 1'b1);
        stop_pixels();
        wait_drained();

        // whole sensor, widest limit; max depth sits on the limit and is dropped
        apply_setup(0, 0, 1024, 1024, 16'hFFFF, 1'b1);
        send_pixel(0, 0, 0, 1'b0);
        send_pixel(16'hFFFF, 1023, 1023, 1'b0);
        send_pixel(16'hFFFE, 0, 0, 1'b0);
        send_pixel(1, 1023, 1023, 1'b1);
        send_pixel(16'hFFFE, 512, 512, 1'b1);      // one-pixel frame
        send_pixel(0, 7, 9, 1'b1);                 // only a missing measurement
        stop_pixels();
        wait_drained();

        // limit of one leaves no depth that can count
        apply_setup(100, 200, 101, 202, 1, 1'b0);
        send_pixel(1, 100, 200, 1'b1);
        stop_pixels();
        wait_drained();

        // one-column strip: probe each side of every edge
        apply_setup(100, 200, 101, 202, 2000, 1'b0);
        send_pixel(5, 99, 200, 1'b0);
        send_pixel(7, 100, 200, 1'b0);
        send_pixel(5, 101, 200, 1'b0);
        send_pixel(8, 100, 201, 1'b0);
        send_pixel(5, 100, 202, 1'b0);
        send_pixel(5, 100, 199, 1'b0);
        send_pixel(1999, 100, 200, 1'b1);
        stop_pixels();
        wait_drained();

        // inverted columns: end below start
        apply_setup(1023, 0, 5, 1024, DEPTH_LIMIT_RESET, 1'b0);
        send_pixel(10, 1023, 0, 1'b0);
        send_pixel(10, 4, 0, 1'b0);
        send_pixel(10, 0, 1023, 1'b1);
        stop_pixels();
        wait_drained();

        // junk upper bits mask to a full region; limit zero blocks everything
        apply_setup(16'hFC00, 16'hFC00, 16'hFC00, 16'hFC00, 0, 1'b0);
        send_pixel(1, 5, 5, 1'b1);
        send_pixel(16'hFFFF, 0, 0, 1'b1);
        stop_pixels();
        wait_drained();

        // --- random frames; first phase runs flat out, one phase holds results off ---
        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(PHASE_PIXELS, p == HOLD_PHASE, p == 0);

        failures = model.failures + model.pending.size();
        $display("Covered %0d frames (%0d with nothing counted) from %0d pixels.",
                 model.frames, model.empty_frames, pixels_sent);
        $display("%0d register writes, %0d cycles of pixel back-pressure, %0d results checked.",
                 cfg_writes, input_stalls, model.checked);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
